// ===== design/shtp_pkg.sv =====
package shtp_pkg;

	// Payload channels of the sensor hub transport
	localparam logic [2:0] CH_RESET = 3'd1;
	localparam logic [2:0] CH_CMD   = 3'd2;
	localparam logic [2:0] CH_INPUT = 3'd3;
	localparam logic [2:0] CH_WAKE  = 3'd4;
	localparam logic [7:0] CH_LIMIT = 8'd6;

	// Marker bytes
	localparam logic [7:0] RESET_DONE_BYTE = 8'h01;
	localparam logic [7:0] CMD_RESP_ID     = 8'hF1;
	localparam logic [7:0] ID_TIMESTAMP    = 8'hFB;
	localparam logic [2:0] TS_SKIP         = 3'd4;
	localparam logic [3:0] CMD_LAST_POS    = 4'd8;

	// Sensor report IDs
	localparam logic [7:0] ID_ACCEL    = 8'h01;
	localparam logic [7:0] ID_GYRO     = 8'h02;
	localparam logic [7:0] ID_MAG      = 8'h03;
	localparam logic [7:0] ID_LIN_ACC  = 8'h04;
	localparam logic [7:0] ID_ROT_VEC  = 8'h05;
	localparam logic [7:0] ID_GRAVITY  = 8'h06;
	localparam logic [7:0] ID_GAME_ROT = 8'h08;
	localparam logic [7:0] ID_GEO_ROT  = 8'h09;
	localparam logic [7:0] ID_ARVR_ROT = 8'h28;

	// Result kinds
	localparam logic [2:0] KIND_QUAT  = 3'd0;
	localparam logic [2:0] KIND_GYRO  = 3'd1;
	localparam logic [2:0] KIND_ACCEL = 3'd2;
	localparam logic [2:0] KIND_MAG   = 3'd3;
	localparam logic [2:0] KIND_RESET = 3'd4;
	localparam logic [2:0] KIND_CMD   = 3'd5;

	localparam int BUF_DEPTH = 14;
	localparam logic [3:0] BUF_LAST = 4'd14;

	// Framer to decoder: what the current byte means
	typedef struct packed {
		logic       start_pkt;
		logic       pay;
		logic [2:0] chan;
		logic       pos0;
		logic       lt9;
		logic [3:0] idx;
	} pay_ev_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [1:0]  status;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
		logic [15:0] w;
		logic [15:0] acc;
	} result_t;

	// Report length by ID, zero for an unknown ID
	function automatic logic [3:0] rpt_len(input logic [7:0] id);
		logic [3:0] l;
		case (id) inside
			ID_ACCEL, ID_GYRO, ID_MAG, ID_LIN_ACC, ID_GRAVITY: l = 4'd10;
			ID_GAME_ROT:                                       l = 4'd12;
			ID_ROT_VEC, ID_GEO_ROT, ID_ARVR_ROT:               l = 4'd14;
			default:                                           l = 4'd0;
		endcase
		return l;
	endfunction

endpackage

// ===== design/shtp_frame.sv =====
module shtp_frame #(
	parameter int KEEP_BYTES       = 128,
	parameter int MAX_PACKET_BYTES = 512
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [7:0]          rx_byte,
	input  logic                frame_start,
	output shtp_pkg::pay_ev_t   ev
);

	localparam int POS_W = $clog2(KEEP_BYTES + 1);

	typedef enum logic [2:0] {
		PH_IDLE    = 3'b001,
		PH_HEADER  = 3'b010,
		PH_PAYLOAD = 3'b100
	} phase_t;

	phase_t           phase_q, phase_d, ph;
	logic [POS_W-1:0] pos_q, pos_d, ps, pos_inc, kept_q, kept_d;
	logic [7:0]       len_lo_q, len_lo_d;
	logic [2:0]       chan_q, chan_d;
	logic [14:0]      len15, body;

	assign len15   = {rx_byte[6:0], len_lo_q};
	assign body    = len15 - 15'd4;
	assign pos_inc = pos_q + POS_W'(1);

	// Header decode and payload position tracking
	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		len_lo_d = len_lo_q;
		chan_d   = chan_q;
		kept_d   = kept_q;
		ev       = '0;
		ev.chan  = chan_q;
		ev.idx   = pos_q[3:0];
		ev.pos0  = (pos_q == '0);
		ev.lt9   = (pos_q < POS_W'(9));
		ph       = frame_start ? PH_HEADER : phase_q;
		ps       = frame_start ? '0 : pos_q;
		unique case (ph)
			PH_HEADER: begin
				phase_d = PH_HEADER;
				if (ps == POS_W'(0)) begin
					len_lo_d = rx_byte;
					pos_d    = POS_W'(1);
				end else if (ps == POS_W'(1)) begin
					if (len15 < 15'd4 || len15 > 15'(MAX_PACKET_BYTES)) begin
						phase_d = PH_IDLE;
					end else begin
						kept_d = (body > 15'(KEEP_BYTES)) ? POS_W'(KEEP_BYTES)
							: body[POS_W-1:0];
						pos_d  = POS_W'(2);
					end
				end else if (ps == POS_W'(2)) begin
					if (rx_byte >= shtp_pkg::CH_LIMIT) begin
						phase_d = PH_IDLE;
					end else begin
						chan_d = rx_byte[2:0];
						pos_d  = POS_W'(3);
					end
				end else begin
					pos_d        = '0;
					ev.start_pkt = en;
					phase_d      = (kept_q == '0) ? PH_IDLE : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (pos_q >= kept_q) begin
					phase_d = PH_IDLE;
				end else begin
					ev.pay = en;
					pos_d  = pos_inc;
					if (pos_inc >= kept_q)
						phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			pos_q    <= '0;
			len_lo_q <= '0;
			chan_q   <= '0;
			kept_q   <= '0;
		end else if (en) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			len_lo_q <= len_lo_d;
			chan_q   <= chan_d;
			kept_q   <= kept_d;
		end
	end

endmodule

// ===== design/shtp_decode.sv =====
module shtp_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [7:0]          rx_byte,
	input  shtp_pkg::pay_ev_t   ev,
	output logic                res_vld,
	output shtp_pkg::result_t   res
);

	logic [7:0] buf_q [shtp_pkg::BUF_DEPTH];
	logic [7:0] buf_n [shtp_pkg::BUF_DEPTH];
	logic [7:0] id_q, id_d;
	logic [3:0] len_q, len_d, off_q, off_d, off_inc, l;
	logic [2:0] skip_q, skip_d;
	logic       aband_q, aband_d;
	logic       wr_en;
	logic [3:0] wr_idx;

	assign off_inc = off_q + 4'd1;
	assign l       = shtp_pkg::rpt_len(rx_byte);

	// Buffer as seen with the current byte written in
	always_comb begin
		for (int i = 0; i < shtp_pkg::BUF_DEPTH; i++)
			buf_n[i] = (wr_en && wr_idx == 4'(i)) ? rx_byte : buf_q[i];
	end

	// Channel handling and report walk
	always_comb begin
		id_d    = id_q;
		len_d   = len_q;
		off_d   = off_q;
		skip_d  = skip_q;
		aband_d = aband_q;
		wr_en   = 1'b0;
		wr_idx  = ev.idx;
		res_vld = 1'b0;
		res     = '0;
		if (ev.start_pkt) begin
			id_d    = '0;
			len_d   = '0;
			off_d   = '0;
			skip_d  = '0;
			aband_d = 1'b0;
		end else if (ev.pay) begin
			case (ev.chan) inside
				shtp_pkg::CH_RESET: begin
					if (ev.pos0 && rx_byte == shtp_pkg::RESET_DONE_BYTE) begin
						res_vld  = 1'b1;
						res.kind = shtp_pkg::KIND_RESET;
					end
				end
				shtp_pkg::CH_CMD: begin
					if (ev.lt9) begin
						wr_en = 1'b1;
						if (ev.idx == shtp_pkg::CMD_LAST_POS &&
						    buf_n[0] == shtp_pkg::CMD_RESP_ID) begin
							res_vld  = 1'b1;
							res.kind = shtp_pkg::KIND_CMD;
							res.x    = {8'h00, buf_n[2]};
							res.y    = {8'h00, buf_n[3]};
							res.z    = {buf_n[6], buf_n[5]};
							res.w    = {buf_n[8], buf_n[7]};
						end
					end
				end
				shtp_pkg::CH_INPUT, shtp_pkg::CH_WAKE: begin
					if (aband_q) begin
						aband_d = 1'b1;
					end else if (skip_q != 3'd0) begin
						skip_d = skip_q - 3'd1;
					end else if (off_q == 4'd0) begin
						if (rx_byte == shtp_pkg::ID_TIMESTAMP) begin
							skip_d = shtp_pkg::TS_SKIP;
						end else if (l == 4'd0) begin
							aband_d = 1'b1;
						end else begin
							id_d   = rx_byte;
							len_d  = l;
							wr_en  = 1'b1;
							wr_idx = 4'd0;
							off_d  = 4'd1;
						end
					end else begin
						wr_en  = (off_q < shtp_pkg::BUF_LAST);
						wr_idx = off_q;
						off_d  = off_inc;
						if (off_inc >= len_q) begin
							off_d      = 4'd0;
							res.status = buf_n[2][1:0];
							res.x      = {buf_n[5], buf_n[4]};
							res.y      = {buf_n[7], buf_n[6]};
							res.z      = {buf_n[9], buf_n[8]};
							res_vld    = 1'b1;
							case (id_q) inside
								shtp_pkg::ID_ROT_VEC, shtp_pkg::ID_GEO_ROT,
								shtp_pkg::ID_ARVR_ROT: begin
									res.kind = shtp_pkg::KIND_QUAT;
									res.w    = {buf_n[11], buf_n[10]};
									res.acc  = {buf_n[13], buf_n[12]};
								end
								shtp_pkg::ID_GAME_ROT: begin
									res.kind = shtp_pkg::KIND_QUAT;
									res.w    = {buf_n[11], buf_n[10]};
								end
								shtp_pkg::ID_GYRO:  res.kind = shtp_pkg::KIND_GYRO;
								shtp_pkg::ID_ACCEL: res.kind = shtp_pkg::KIND_ACCEL;
								shtp_pkg::ID_MAG:   res.kind = shtp_pkg::KIND_MAG;
								default: begin
									res_vld = 1'b0;
									res     = '0;
								end
							endcase
						end
					end
				end
				default: begin
					res_vld = 1'b0;
				end
			endcase
		end
	end

	// Report buffer, written one byte at a time
	always_ff @(posedge clk) begin
		if (en && wr_en)
			buf_q[wr_idx] <= rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q    <= '0;
			len_q   <= '0;
			off_q   <= '0;
			skip_q  <= '0;
			aband_q <= 1'b0;
		end else if (en) begin
			id_q    <= id_d;
			len_q   <= len_d;
			off_q   <= off_d;
			skip_q  <= skip_d;
			aband_q <= aband_d;
		end
	end

endmodule

// ===== design/shtp_sensor_report_parser.sv =====
// Sensor-hub packet parser. Each slave-side transfer carries one received
// byte; tuser high marks the first byte of a bus transaction. The block
// checks the 4-byte header, keeps the first KEEP_BYTES payload bytes, walks
// the sensor reports on channels 3 and 4 and sends one master-side transfer
// per finished rotation-vector, gyro, accel or magnetometer report, and for
// reset-complete (channel 1) and command responses (channel 2). One byte is
// taken every cycle unless a waiting result holds the flow; a byte passes
// the input register, and its result, if any, is written to the output
// register, raising m_tvalid, once that register is free or m_tready is
// high. s_tready follows m_tready combinationally when a result and an input byte are waiting.
module shtp_sensor_report_parser #(
	parameter int KEEP_BYTES       = 128,
	parameter int MAX_PACKET_BYTES = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // status[1:0] x[17:2] y[33:18] z[49:34]
	                               // w[65:50] accuracy[81:66], zero above
	output logic [2:0]  m_tuser    // kind
);

	logic              vld_s1, start_s1, advance, res_vld;
	logic [7:0]        byte_s1;
	shtp_pkg::pay_ev_t ev;
	shtp_pkg::result_t res, res_q;

	assign advance  = vld_s1 && (!m_tvalid || m_tready);
	assign s_tready = !vld_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (s_tready)
			vld_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	shtp_frame #(
		.KEEP_BYTES      (KEEP_BYTES),
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.rx_byte    (byte_s1),
		.frame_start(start_s1),
		.ev         (ev)
	);

	shtp_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.rx_byte(byte_s1),
		.ev     (ev),
		.res_vld(res_vld),
		.res    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (advance)
			m_tvalid <= res_vld;
		else if (m_tready)
			m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && res_vld)
			res_q <= res;
	end

	assign m_tuser = res_q.kind;
	assign m_tdata = {6'd0, res_q.acc, res_q.w, res_q.z, res_q.y, res_q.x, res_q.status};

	// Checks
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= shtp_pkg::KIND_CMD)
		else $error("result kind out of range");

	a_msg_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == shtp_pkg::KIND_RESET || m_tuser == shtp_pkg::KIND_CMD)
		|-> m_tdata[1:0] == 2'd0)
		else $error("status set on a message result");

	a_vec_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == shtp_pkg::KIND_GYRO || m_tuser == shtp_pkg::KIND_ACCEL ||
		m_tuser == shtp_pkg::KIND_MAG) |-> m_tdata[81:50] == 32'd0)
		else $error("w or accuracy set on a three-axis result");

	a_reset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == shtp_pkg::KIND_RESET |-> m_tdata == 88'd0)
		else $error("reset-complete result carries data");

endmodule
